// ===== rtl/core/lchd_pkg.sv =====
package lchd_pkg;

    localparam int KEY_W             = 32;
    localparam int COUNT_W           = 16;
    localparam int CAP_W             = 5;
    localparam int TOTAL_W           = 32;
    localparam int MAX_ENTRIES_DFLT  = 16;

    localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // result tdata: hit, hit_total, zero fill to a byte boundary
    localparam int RES_BITS = 1 + TOTAL_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

// ===== rtl/core/lfu_cache_hit_detector_core.sv =====
// LFU cache hit detector. Each key transaction on s_axis is looked up in a
// least-frequently-used cache of up to min(max(capacity,1), MAX_ENTRIES)
// entries, and exactly one result transaction comes out on m_axis with the
// hit flag and the saturating number of hits since reset (this key included).
// Entries live in one synchronous RAM (one write and one read port, registered
// read) laid out as a binary min-heap on 16-bit use counts: root in
// slot 0, children of slot i in 2i+1 and 2i+2. A hit bumps the count
// (saturating) and sifts the entry down, swapping with the smaller child (left
// on ties) while that child's count is strictly lower. A miss with room
// appends the key with count 0 and rotates it up its path to the root; a miss
// on a full cache overwrites the root. Per key: the key is accepted in idle;
// the search streams the RAM one slot per cycle and compares each word read
// with the key; a sift-down reads the left and, if present, the right child
// and writes one slot per level until the entry settles; an insert reads each
// parent and shifts it down one level until the new entry reaches the root;
// then the result is handed to the output register. The block takes one key
// at a time; a finished result sits in the output register so the next key
// can already be accepted while it waits. The RAM needs no clearing pass:
// only slots below the fill count are ever read. capacity may only be
// written while idle; a lower value than the fill count keeps the entries
// held and makes every miss replace the root.
module lfu_cache_hit_detector_core #(
    parameter int MAX_ENTRIES = lchd_pkg::MAX_ENTRIES_DFLT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // capacity register write
    input  logic                          cfg_we,
    input  logic [lchd_pkg::CAP_W-1:0]    cfg_wdata,
    // key transactions; tdata: key[31:0]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lchd_pkg::KEY_W-1:0]    s_axis_tdata,
    // result transactions; tdata: hit[0], hit_total[32:1], zero fill above
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lchd_pkg::RES_W-1:0]    m_axis_tdata
);
    import lchd_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CH_W  = IDX_W + 2;
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(MAX_ENTRIES);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SEARCH    = 9'b000000010,
        ST_SD_CHECK  = 9'b000000100,
        ST_SD_LEFT   = 9'b000001000,
        ST_SD_RIGHT  = 9'b000010000,
        ST_SD_DECIDE = 9'b000100000,
        ST_UP_STEP   = 9'b001000000,
        ST_UP_WRITE  = 9'b010000000,
        ST_FINISH    = 9'b100000000
    } state_t;

    // heap RAM
    entry_t entry_mem [MAX_ENTRIES];
    entry_t rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // control state
    state_t             state_reg, state_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [TOTAL_W-1:0] hits_reg, hits_next;
    logic               m_valid_reg, m_valid_next;
    logic [OCC_W-1:0]   idx_reg, idx_next;       // next slot to read in search
    logic               rdv_reg, rdv_next;       // search read in flight
    logic [IDX_W-1:0]   rdidx_reg, rdidx_next;   // slot of the data in flight

    // payload
    logic [KEY_W-1:0]   key_reg, key_next;
    entry_t             cur_reg, cur_next;       // entry being placed
    entry_t             child_reg, child_next;   // chosen child in sift-down
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   cpos_reg, cpos_next;
    logic [IDX_W-1:0]   parent_reg, parent_next;
    logic               hit_reg, hit_next;
    logic               m_hit_reg, m_hit_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;

    logic [CH_W-1:0]  left_w, right_w, occ_w;
    logic [CMP_W-1:0] occ_c, cap_c;
    logic             room;
    logic             out_free;
    logic             key_match;

    assign left_w  = (CH_W'(pos_reg) << 1) + CH_W'(1);
    assign right_w = left_w + CH_W'(1);
    assign occ_w   = CH_W'(occ_reg);

    // capacity zero acts as one, anything above the RAM depth as the depth
    assign occ_c = CMP_W'(occ_reg);
    assign cap_c = CMP_W'(cap_reg);
    assign room  = ((occ_c < cap_c) || (occ_reg == '0)) && (occ_reg < OCC_FULL);

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign key_match = rdv_reg && (rd_data_reg.key == key_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = RES_W'({m_total_reg, m_hit_reg});

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        cap_next     = cfg_we ? cfg_wdata : cap_reg;
        hits_next    = hits_reg;
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        rdv_next     = 1'b0;
        rdidx_next   = rdidx_reg;
        key_next     = key_reg;
        cur_next     = cur_reg;
        child_next   = child_reg;
        pos_next     = pos_reg;
        cpos_next    = cpos_reg;
        parent_next  = parent_reg;
        hit_next     = hit_reg;
        m_hit_next   = m_hit_reg;
        m_total_next = m_total_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = cur_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    key_next   = s_axis_tdata;
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                // stream slots through the RAM, compare on the registered read word
                if (idx_reg < occ_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[IDX_W-1:0];
                    rdv_next   = 1'b1;
                    rdidx_next = idx_reg[IDX_W-1:0];
                    idx_next   = idx_reg + OCC_W'(1);
                end
                if (key_match)
                begin
                    hit_next      = 1'b1;
                    pos_next      = rdidx_reg;
                    cur_next.key  = key_reg;
                    cur_next.count = (rd_data_reg.count == COUNT_MAX) ?
                                     COUNT_MAX : rd_data_reg.count + COUNT_W'(1);
                    if (hits_reg != TOTAL_MAX)
                    begin
                        hits_next = hits_reg + TOTAL_W'(1);
                    end
                    rdv_next   = 1'b0;
                    state_next = ST_SD_CHECK;
                end
                else if (!rdv_reg && (idx_reg >= occ_reg)
                         || rdv_reg && (OCC_W'(rdidx_reg) + OCC_W'(1) == occ_reg))
                begin
                    // miss: every held slot compared
                    hit_next       = 1'b0;
                    cur_next.key   = key_reg;
                    cur_next.count = '0;
                    rdv_next       = 1'b0;
                    if (room)
                    begin
                        pos_next   = occ_reg[IDX_W-1:0];
                        occ_next   = occ_reg + OCC_W'(1);
                        state_next = ST_UP_STEP;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = '{key: key_reg, count: '0};
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SD_CHECK:
            begin
                if (left_w >= occ_w)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = left_w[IDX_W-1:0];
                    state_next = ST_SD_LEFT;
                end
            end

            ST_SD_LEFT:
            begin
                child_next = rd_data_reg;
                cpos_next  = left_w[IDX_W-1:0];
                if (right_w < occ_w)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = right_w[IDX_W-1:0];
                    state_next = ST_SD_RIGHT;
                end
                else
                begin
                    state_next = ST_SD_DECIDE;
                end
            end

            ST_SD_RIGHT:
            begin
                // left wins ties
                if (rd_data_reg.count < child_reg.count)
                begin
                    child_next = rd_data_reg;
                    cpos_next  = right_w[IDX_W-1:0];
                end
                state_next = ST_SD_DECIDE;
            end

            ST_SD_DECIDE:
            begin
                wr_en = 1'b1;
                wr_addr = pos_reg;
                if (child_reg.count >= cur_reg.count)
                begin
                    wr_data    = cur_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    // child moves up, entry keeps sinking
                    wr_data    = child_reg;
                    pos_next   = cpos_reg;
                    state_next = ST_SD_CHECK;
                end
            end

            ST_UP_STEP:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    parent_next = (pos_reg - IDX_W'(1)) >> 1;
                    rd_en       = 1'b1;
                    rd_addr     = (pos_reg - IDX_W'(1)) >> 1;
                    state_next  = ST_UP_WRITE;
                end
            end

            ST_UP_WRITE:
            begin
                // parent shifts down one level along the path
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = rd_data_reg;
                pos_next   = parent_reg;
                state_next = ST_UP_STEP;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_reg;
                    m_total_next = hits_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            cap_reg     <= CAP_RESET;
            hits_reg    <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            rdv_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            cap_reg     <= cap_next;
            hits_reg    <= hits_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            rdv_reg     <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdidx_reg   <= rdidx_next;
        key_reg     <= key_next;
        cur_reg     <= cur_next;
        child_reg   <= child_next;
        pos_reg     <= pos_next;
        cpos_reg    <= cpos_next;
        parent_reg  <= parent_next;
        hit_reg     <= hit_next;
        m_hit_reg   <= m_hit_next;
        m_total_reg <= m_total_next;
    end

    // heap RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

endmodule

// ===== sim/lfu_cache_hit_detector_core_tb.sv =====
module lfu_cache_hit_detector_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lchd_pkg::*;

    localparam int          DEPTH       = MAX_ENTRIES_DFLT;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          POOL_SIZE   = 24;
    localparam int          PHASE_KEYS  = 115;
    // hits on one key in the back-to-back run
    localparam int          STEADY_HITS = 8;

    localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_ONES = 32'hFFFF_FFFF;

    // receiver stall patterns
    typedef enum int unsigned {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    typedef struct {
        logic               hit;
        logic [TOTAL_W-1:0] total;
    } lookup_result_t;

    // Shadow of the cache: heap of keys and use counts, fill level, hit total.
    // note_key() updates it for every accepted key transaction and queues the
    // expected result; check_result() pops and compares.
    class lfu_scoreboard;
        logic [KEY_W-1:0]   slot_key   [DEPTH];
        logic [COUNT_W-1:0] slot_count [DEPTH];
        int unsigned        fill;
        logic [TOTAL_W-1:0] hit_count;
        logic [CAP_W-1:0]   capacity;
        lookup_result_t     expected_results[$];
        int unsigned        failures;
        int unsigned        hits_checked;
        int unsigned        misses_checked;

        function new();
            fill           = 0;
            hit_count      = '0;
            capacity       = CAP_RESET;
            failures       = 0;
            hits_checked   = 0;
            misses_checked = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [KEY_W-1:0]   k;
            logic [COUNT_W-1:0] c;
            k             = slot_key[a];
            c             = slot_count[a];
            slot_key[a]   = slot_key[b];
            slot_count[a] = slot_count[b];
            slot_key[b]   = k;
            slot_count[b] = c;
        endfunction

        function void note_key(logic [KEY_W-1:0] key);
            int             found;
            int unsigned    limit;
            int unsigned    pos;
            int unsigned    pick;
            bit             done;
            lookup_result_t res;
            found = -1;
            if (capacity == 0)
                limit = 1;
            else if (capacity > DEPTH)
                limit = DEPTH;
            else
                limit = capacity;
            for (int i = 0; i < fill && found < 0; i++)
                if (slot_key[i] == key)
                    found = i;
            if (found >= 0)
            begin
                if (slot_count[found] != COUNT_MAX)
                    slot_count[found]++;
                // sift down: smaller child, left on ties, only if strictly lower
                pos  = found;
                done = 1'b0;
                while (!done)
                begin
                    pick = 2 * pos + 1;
                    if (pick >= fill)
                        done = 1'b1;
                    else
                    begin
                        if (pick + 1 < fill && slot_count[pick+1] < slot_count[pick])
                            pick++;
                        if (slot_count[pick] >= slot_count[pos])
                            done = 1'b1;
                        else
                        begin
                            swap_slots(pos, pick);
                            pos = pick;
                        end
                    end
                end
                if (hit_count != TOTAL_MAX)
                    hit_count++;
            end
            else if (fill < limit)
            begin
                // append, then rotate unconditionally up to the root
                pos             = fill;
                slot_key[pos]   = key;
                slot_count[pos] = '0;
                fill++;
                while (pos != 0)
                begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
            else
            begin
                slot_key[0]   = key;
                slot_count[0] = '0;
            end
            res.hit          = (found >= 0);
            res.total        = hit_count;
            expected_results = {expected_results, res};
        endfunction

        function void check_result(logic [RES_W-1:0] word);
            lookup_result_t exp;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction, tdata %h", word);
                failures++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (word[0] !== exp.hit)
                begin
                    $error("hit: expected %0d, actual %0d", exp.hit, word[0]);
                    failures++;
                end
                if (word[TOTAL_W:1] !== exp.total)
                begin
                    $error("hit_total: expected %0d, actual %0d", exp.total, word[TOTAL_W:1]);
                    failures++;
                end
                if (word[RES_W-1:TOTAL_W+1] !== '0)
                begin
                    $error("fill: expected 0, actual %h", word[RES_W-1:TOTAL_W+1]);
                    failures++;
                end
                if (exp.hit)
                    hits_checked++;
                else
                    misses_checked++;
            end
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [CAP_W-1:0]   cfg_wdata     = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [KEY_W-1:0]   s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [RES_W-1:0]   m_axis_tdata;

    lfu_scoreboard      sb;
    int unsigned        cycle_count     = 0;
    int unsigned        keys_sent       = 0;
    int unsigned        capacity_writes = 0;
    int unsigned        burst_left      = 1;
    bit                 steady_flow     = 1'b0;   // no gaps, no stalls
    ready_mode_t        ready_mode      = READY_ALWAYS;
    int unsigned        mode_left       = 0;
    int unsigned        period_ctr      = 0;
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];

    lfu_cache_hit_detector_core #(
        .MAX_ENTRIES (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // key[31:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)      // hit[0], hit_total[32:1], zero fill
    );

    always #5 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check every accepted transaction, then pick tready for
    // the next edge. The stall pattern is redrawn when its random run length runs out.
    always @(posedge clk)
    begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 300);
        end
        else
            mode_left--;
        period_ctr++;
        if (steady_flow)
            m_axis_tready <= 1'b1;
        else
            case (ready_mode)
                READY_ALWAYS: m_axis_tready <= 1'b1;
                READY_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 0);
                READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:      m_axis_tready <= (period_ctr % 5 != 0);
            endcase
    end

    // One key transaction. Holds tvalid high into the next key unless the
    // current burst ends with a gap.
    task automatic send_key(input logic [KEY_W-1:0] key);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_key(key);
        keys_sent++;
        if (!steady_flow)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                // mostly short bursts, now and then a long stretch with no gaps
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Drop tvalid and wait until every result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
    endtask

    // Capacity is only written with the block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.capacity = value;
        capacity_writes++;
    endtask

    initial
    begin
        logic [CAP_W-1:0] phase_caps [] = '{5'd16, 5'd5, 5'd0, 5'd31, 5'd1, 5'd12, 5'd3,
                                            5'd17, 5'd8, 5'd2, 5'd16, 5'd9, 5'd4, 5'd16};
        int unsigned      r;
        logic [KEY_W-1:0] key;

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Capacity zero acts as one entry: every miss after the first replaces the root.
        write_capacity(5'd0);
        send_key(KEY_MIN);
        send_key(KEY_MIN);
        send_key(KEY_MAX);
        send_key(KEY_ZERO);
        send_key(KEY_ONES);

        // Back-to-back hits on one key alone in the cache, no gaps or stalls.
        write_capacity(5'd1);
        steady_flow = 1'b1;
        repeat (STEADY_HITS) send_key(KEY_ONES);
        steady_flow = 1'b0;

        // Capacity above the maximum acts as the maximum. A new key rotates to
        // the root; five hits keep it there while its count stays below the
        // old key's.
        write_capacity(5'd31);
        send_key(KEY_MAX);
        repeat (5) send_key(KEY_MAX);

        // Full at two entries: the miss evicts the root, the lookups show which.
        write_capacity(5'd2);
        send_key(32'h0000_0001);
        send_key(KEY_ONES);
        send_key(KEY_MAX);

        write_capacity(5'd16);
        send_key(32'h5555_5555);
        send_key(32'hAAAA_AAAA);
        send_key(KEY_MIN);
        send_key(KEY_ZERO);
        send_key(32'hAAAA_AAAA);
        send_key(KEY_ZERO);

        // Capacity lowered below the fill level: entries stay, misses hit the root.
        write_capacity(5'd3);
        send_key(32'h1357_9BDF);
        send_key(32'hAAAA_AAAA);

        // Random phases. Keys come mostly from the held entries (hits) and a
        // per-phase pool (mix of hits, appends and evictions), the rest fully
        // random so every key bit toggles.
        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            key_pool[0] = KEY_MIN;
            key_pool[1] = KEY_MAX;
            key_pool[2] = KEY_ZERO;
            key_pool[3] = KEY_ONES;
            for (int i = 4; i < POOL_SIZE; i++)
                key_pool[i] = $urandom;
            repeat (PHASE_KEYS)
            begin
                r = $urandom_range(0, 99);
                if (r < 45 && sb.fill != 0)
                    key = sb.slot_key[$urandom_range(0, sb.fill - 1)];
                else if (r < 85)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    key = $urandom;
                send_key(key);
            end
        end

        wait_idle();
        // late or extra results would still be caught by the checker here
        repeat (50) @(posedge clk);

        $display("Covered %0d key lookups (%0d hits, %0d misses) over %0d capacity writes",
                 keys_sent, sb.hits_checked, sb.misses_checked, capacity_writes);
        $display("from 0 to 31, with bursts, gaps and receiver stalls mixed in.");
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lchd_pkg.sv
rtl/core/lfu_cache_hit_detector_core.sv
sim/lfu_cache_hit_detector_core_tb.sv
